>>> hw/rtl/sorted_priority_queue_assert.svh
// Assertion macros used by the checker file of the sorted priority queue.
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SPQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted_priority_queue check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define SPQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted_priority_queue check failed");

`endif

>>> hw/rtl/spq_pkg.sv
// Package: sizes, codes, types and compare helper of the sorted priority queue.
package spq_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int OCC_W    = 5;
    localparam int DATA_W   = 32;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    localparam logic [1:0] ST_ENQUEUED = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_DEQUEUED = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    // occupancy as reported when the queue is full (fits the port width)
    localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(CAPACITY);

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] prio;
    } entry_t;

    typedef struct packed {
        logic enq;
        logic deq;
    } cell_ctl_t;

    function automatic logic prio_le(input logic signed [DATA_W-1:0] a,
                                     input logic signed [DATA_W-1:0] b);
        prio_le = (a <= b);
    endfunction

endpackage

>>> hw/rtl/spq_if.sv
// Channel interfaces: enqueue/dequeue requests in, results out.
interface spq_in_if;
    logic                                valid;
    logic                                ready;
    logic                                operation;
    logic signed [spq_pkg::DATA_W-1:0]   item_value;
    logic signed [spq_pkg::DATA_W-1:0]   item_priority;

    modport source (output valid, output operation, output item_value,
                    output item_priority, input ready);
    modport sink   (input valid, input operation, input item_value,
                    input item_priority, output ready);
endinterface

interface spq_out_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          status;
    logic signed [spq_pkg::DATA_W-1:0]   out_value;
    logic signed [spq_pkg::DATA_W-1:0]   out_priority;
    logic [spq_pkg::OCC_W-1:0]           occupancy;

    modport source (output valid, output status, output out_value,
                    output out_priority, output occupancy, input ready);
    modport sink   (input valid, input status, input out_value,
                    input out_priority, input occupancy, output ready);
endinterface

>>> hw/rtl/spq_cell.sv
// One slot of the sorted chain: keeps, takes the new entry, or shifts.
module spq_cell (
    input  logic               clk,
    input  spq_pkg::cell_ctl_t ctl,
    input  logic               occupied,
    input  spq_pkg::entry_t    new_entry,
    input  spq_pkg::entry_t    left_entry,
    input  logic               left_stay,
    input  spq_pkg::entry_t    right_entry,
    output logic               stay,
    output spq_pkg::entry_t    entry
);

    spq_pkg::entry_t entry_reg;
    spq_pkg::entry_t entry_next;

    // stay: this slot sorts at or before the new entry, so it holds still
    assign stay  = occupied && spq_pkg::prio_le(entry_reg.prio, new_entry.prio);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        priority if (ctl.enq)
        begin
            if (stay)
                entry_next = entry_reg;
            else if (left_stay)
                entry_next = new_entry;
            else
                entry_next = left_entry;
        end
        else if (ctl.deq)
        begin
            entry_next = right_entry;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

>>> hw/rtl/sorted_priority_queue.sv
// Sorted priority queue (smallest priority first) built as a chain of cells.
//
// Usage:
//   in_ch  carries one request beat: operation (0 enqueue, 1 dequeue),
//          item_value and item_priority (signed). Beat taken on valid & ready.
//   out_ch returns exactly one result beat per request: status (0 enqueued,
//          1 rejected full, 2 dequeued, 3 empty), out_value / out_priority of
//          the dequeued entry (zero otherwise) and occupancy after the request.
//   Result: registered; it shows in the cycle after the request is taken.
//   Throughput: one request per cycle while out_ch.ready is high; every cell
//          compares its priority with the new key in parallel and shifts in
//          the same cycle, so no search loop stands in the path.
//   Stall: the single output register holds its beat while out_ch.ready is
//          low; in_ch.ready then drops and no request is taken until the
//          result leaves (ready = output empty or being drained this cycle).
//   Reset: rst_n (async, low) empties the queue and the output register.
//          Slot contents are not cleared; only slots below the count are used.
//   Equal priorities leave in arrival order: a new entry goes behind every
//   stored entry whose priority is less than or equal to its own.
module sorted_priority_queue (
    input  logic      clk,
    input  logic      rst_n,
    spq_in_if.sink    in_ch,
    spq_out_if.source out_ch
);

    localparam int N = spq_pkg::CAPACITY;

    logic [spq_pkg::CNT_W-1:0] count_reg;
    logic [spq_pkg::CNT_W-1:0] count_next;

    logic                          out_valid_reg;
    logic [1:0]                    status_reg;
    logic [1:0]                    status_next;
    spq_pkg::entry_t               result_reg;
    spq_pkg::entry_t               result_next;
    logic [spq_pkg::OCC_W-1:0]     occupancy_reg;

    logic               accept;
    logic               is_full;
    logic               is_empty;
    spq_pkg::cell_ctl_t ctl;
    spq_pkg::entry_t    new_entry;

    spq_pkg::entry_t    cell_entry [N];
    logic               cell_stay  [N];

    // Take a request whenever the result slot is free or draining now.
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;

    assign is_full  = (count_reg == spq_pkg::CNT_W'(N));
    assign is_empty = (count_reg == '0);

    assign ctl.enq = accept && (in_ch.operation == spq_pkg::OP_ENQ) && !is_full;
    assign ctl.deq = accept && (in_ch.operation == spq_pkg::OP_DEQ) && !is_empty;

    assign new_entry.value = in_ch.item_value;
    assign new_entry.prio  = in_ch.item_priority;

    // The chain: slot 0 is the front. Insert shifts right from the insertion
    // point; removal shifts everything one slot left.
    for (genvar i = 0; i < N; i++)
    begin : g_cell
        spq_pkg::entry_t left_entry;
        spq_pkg::entry_t right_entry;
        logic            left_stay;
        logic            occupied;

        assign occupied = (count_reg > spq_pkg::CNT_W'(i));

        if (i == 0)
        begin : g_head
            assign left_entry = new_entry;
            assign left_stay  = 1'b0;
        end
        else
        begin : g_body
            assign left_entry = cell_entry[i-1];
            assign left_stay  = cell_stay[i-1];
        end

        if (i == N - 1)
        begin : g_tail
            assign right_entry = cell_entry[i];
        end
        else
        begin : g_mid
            assign right_entry = cell_entry[i+1];
        end

        spq_cell u_cell (
            .clk         (clk),
            .ctl         (ctl),
            .occupied    (occupied),
            .new_entry   (new_entry),
            .left_entry  (left_entry),
            .left_stay   (left_stay),
            .right_entry (right_entry),
            .stay        (cell_stay[i]),
            .entry       (cell_entry[i])
        );
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctl.enq)
            count_next = count_reg + spq_pkg::CNT_W'(1);
        else if (ctl.deq)
            count_next = count_reg - spq_pkg::CNT_W'(1);
    end

    always_comb
    begin
        result_next = '0;
        if (in_ch.operation == spq_pkg::OP_ENQ)
        begin
            status_next = is_full ? spq_pkg::ST_FULL : spq_pkg::ST_ENQUEUED;
        end
        else if (is_empty)
        begin
            status_next = spq_pkg::ST_EMPTY;
        end
        else
        begin
            status_next = spq_pkg::ST_DEQUEUED;
            result_next = cell_entry[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Result payload, loaded only with a new beat.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg    <= status_next;
            result_reg    <= result_next;
            occupancy_reg <= spq_pkg::OCC_W'(count_next);
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.status       = status_reg;
    assign out_ch.out_value    = result_reg.value;
    assign out_ch.out_priority = result_reg.prio;
    assign out_ch.occupancy    = occupancy_reg;

endmodule

>>> hw/rtl/spq_checker.sv
// Port-level checks on the sorted priority queue, bound to the top level.
`include "sorted_priority_queue_assert.svh"

module spq_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic [1:0]                        status,
    input logic signed [spq_pkg::DATA_W-1:0] out_value,
    input logic signed [spq_pkg::DATA_W-1:0] out_priority,
    input logic [spq_pkg::OCC_W-1:0]         occupancy
);

    // every accepted request yields a result beat in the next cycle
    `SPQ_ASSERT_NEXT(a_result_follows, in_valid && in_ready, out_valid)

    // a stalled result holds its payload
    `SPQ_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready,
        out_valid && $stable(status) && $stable(out_value) && $stable(occupancy))

    // empty report carries zero payload and zero occupancy
    `SPQ_ASSERT_NOW(a_empty_zero, out_valid && status == spq_pkg::ST_EMPTY,
        out_value == '0 && out_priority == '0 && occupancy == '0)

    // rejection only happens at full occupancy
    `SPQ_ASSERT_NOW(a_full_occ, out_valid && status == spq_pkg::ST_FULL,
        occupancy == spq_pkg::OCC_FULL && out_value == '0)

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .status       (out_ch.status),
    .out_value    (out_ch.out_value),
    .out_priority (out_ch.out_priority),
    .occupancy    (out_ch.occupancy)
);

>>> tb/sv/sorted_priority_queue_tb.sv
// Testbench for sorted_priority_queue: enqueue/dequeue traffic checked against a sorted-list model.
`timescale 1ns / 100ps

module sorted_priority_queue_tb;

    // Roughly the number of request beats in the whole run.
    localparam int ITEM_TARGET = 1650;
    // This limit only catches a hang; normal runs end before it.
    localparam int CYCLE_LIMIT = 100000;
    // Window of cycles where neither side idles, for back-to-back traffic.
    localparam int CALM_START  = 900;
    localparam int CALM_STOP   = 1500;
    // Percent of cycles where a side idles outside the calm window.
    localparam int IDLE_PCT    = 14;
    // Extra wait at the end for stray result beats.
    localparam int DRAIN_TAIL  = 8;

    typedef struct packed {
        logic                              op;
        logic signed [spq_pkg::DATA_W-1:0] value;
        logic signed [spq_pkg::DATA_W-1:0] prio;
    } pq_request_t;

    typedef struct packed {
        logic [1:0]                        status;
        logic signed [spq_pkg::DATA_W-1:0] value;
        logic signed [spq_pkg::DATA_W-1:0] prio;
        logic [spq_pkg::OCC_W-1:0]         occupancy;
    } pq_result_t;

    logic clk;
    logic rst_n;

    spq_in_if  in_ch ();
    spq_out_if out_ch ();

    sorted_priority_queue u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Clock: 10 ns period.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Request beats not yet accepted. The front beat is the one being presented.
    pq_request_t pending_reqs[$];
    // Results that the model predicts and the block has not returned yet, oldest first.
    pq_result_t  expected_results[$];

    // Model copy of the sorted store. Slot 0 is the front entry.
    logic signed [spq_pkg::DATA_W-1:0] held_val  [spq_pkg::CAPACITY];
    logic signed [spq_pkg::DATA_W-1:0] held_prio [spq_pkg::CAPACITY];
    int                                held_count;

    int  cycle_count;
    int  mismatch_count;
    // Set by the monitor at the rising edge when the presented beat is taken.
    // The driver clears it at the next falling edge.
    bit  req_accepted;

    task automatic flag_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    // Apply one request to the model store and return the result the block should give.
    // An enqueue goes behind every entry whose priority is less than or equal to its own,
    // so equal priorities leave in arrival order. A full enqueue or an empty dequeue
    // leaves the store as it is.
    function automatic pq_result_t apply_request(input pq_request_t req);
        pq_result_t res;
        int         slot;
        int         i;
        res = '0;
        if (req.op == spq_pkg::OP_ENQ)
        begin
            if (held_count >= spq_pkg::CAPACITY)
                res.status = spq_pkg::ST_FULL;
            else
            begin
                slot = 0;
                while (slot < held_count && held_prio[slot] <= req.prio)
                    slot++;
                for (i = held_count; i > slot; i--)
                begin
                    held_val[i]  = held_val[i-1];
                    held_prio[i] = held_prio[i-1];
                end
                held_val[slot]  = req.value;
                held_prio[slot] = req.prio;
                held_count++;
                res.status = spq_pkg::ST_ENQUEUED;
            end
        end
        else
        begin
            if (held_count == 0)
                res.status = spq_pkg::ST_EMPTY;
            else
            begin
                res.value = held_val[0];
                res.prio  = held_prio[0];
                for (i = 1; i < held_count; i++)
                begin
                    held_val[i-1]  = held_val[i];
                    held_prio[i-1] = held_prio[i];
                end
                held_count--;
                res.status = spq_pkg::ST_DEQUEUED;
            end
        end
        res.occupancy = spq_pkg::OCC_W'(held_count);
        return res;
    endfunction

    task automatic add_request(input logic op, input logic [spq_pkg::DATA_W-1:0] value,
                               input logic [spq_pkg::DATA_W-1:0] prio);
        pq_request_t req;
        req.op    = op;
        req.value = value;
        req.prio  = prio;
        pending_reqs.push_back(req);
    endtask

    // Priority mix: 40 percent in a narrow band around zero, so ties and FIFO order get
    // exercised often. 15 percent come from a fixed set at the signed extremes, -1 and 0, and the rest are full range.
    function automatic logic [spq_pkg::DATA_W-1:0] pick_priority();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 40)
            return spq_pkg::DATA_W'($urandom_range(6)) - spq_pkg::DATA_W'(3);
        if (roll < 55)
        begin
            case ($urandom_range(5))
                0:       return 32'h8000_0000;
                1:       return 32'h8000_0001;
                2:       return 32'h7fff_ffff;
                3:       return 32'h7fff_fffe;
                4:       return 32'hffff_ffff;
                default: return 32'h0000_0000;
            endcase
        end
        return $urandom;
    endfunction

    // True when this side should idle this cycle. There is no idling inside the calm window.
    function automatic bit take_break();
        if (cycle_count >= CALM_START && cycle_count < CALM_STOP)
            return 1'b0;
        return $urandom_range(99) < IDLE_PCT;
    endfunction

    // Driver: all inputs change on the falling edge. A presented beat is held
    // until the monitor sees it taken. Only then is the next beat (or a gap) chosen.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_ch.valid || req_accepted)
            begin
                if (req_accepted)
                begin
                    void'(pending_reqs.pop_front());
                    req_accepted = 1'b0;
                end
                if (pending_reqs.size() != 0 && !take_break())
                begin
                    in_ch.valid         <= 1'b1;
                    in_ch.operation     <= pending_reqs[0].op;
                    in_ch.item_value    <= pending_reqs[0].value;
                    in_ch.item_priority <= pending_reqs[0].prio;
                end
                else
                    in_ch.valid <= 1'b0;
            end
            out_ch.ready <= !take_break();
        end
    end

    // Monitor: sample both channels on the rising edge. Accepted requests go
    // through the model and accepted results are checked against the oldest prediction.
    always @(posedge clk)
    begin : monitor_proc
        pq_request_t seen;
        pq_result_t  want;
        cycle_count++;
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                seen.op    = in_ch.operation;
                seen.value = in_ch.item_value;
                seen.prio  = in_ch.item_priority;
                expected_results.push_back(apply_request(seen));
                req_accepted = 1'b1;
            end
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_results.size() == 0)
                    flag_mismatch("result beat with no request outstanding");
                else
                begin
                    want = expected_results.pop_front();
                    if (out_ch.status !== want.status)
                        flag_mismatch($sformatf("status %0d, want %0d",
                                                out_ch.status, want.status));
                    if (out_ch.out_value !== want.value)
                        flag_mismatch($sformatf("out_value %h, want %h",
                                                out_ch.out_value, want.value));
                    if (out_ch.out_priority !== want.prio)
                        flag_mismatch($sformatf("out_priority %h, want %h",
                                                out_ch.out_priority, want.prio));
                    if (out_ch.occupancy !== want.occupancy)
                        flag_mismatch($sformatf("occupancy %0d, want %0d",
                                                out_ch.occupancy, want.occupancy));
                end
            end
        end
    end

    // Watchdog.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin : stimulus_proc
        int          burst_left;
        int unsigned enq_pct;
        int          total;

        rst_n               = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.operation     = spq_pkg::OP_ENQ;
        in_ch.item_value    = '0;
        in_ch.item_priority = '0;
        out_ch.ready        = 1'b0;
        held_count          = 0;
        cycle_count         = 0;
        mismatch_count      = 0;
        req_accepted        = 1'b0;

        // Directed part.
        // Dequeue from an empty queue.
        add_request(spq_pkg::OP_DEQ, 32'h1234_5678, 32'h8765_4321);
        // Fill to capacity. The priorities hit both signed extremes and zero,
        // the set has several ties (5, the minimum, the maximum, zero, -1) to check
        // FIFO order, and the values cover the extremes and alternating bits.
        add_request(spq_pkg::OP_ENQ, 32'h7fff_ffff, 32'd5);
        add_request(spq_pkg::OP_ENQ, 32'h8000_0000, 32'h7fff_ffff);
        add_request(spq_pkg::OP_ENQ, 32'h0000_0000, 32'h8000_0000);
        add_request(spq_pkg::OP_ENQ, 32'hffff_ffff, 32'd5);
        add_request(spq_pkg::OP_ENQ, 32'd1,         32'd0);
        add_request(spq_pkg::OP_ENQ, 32'd2,         32'hffff_ffff);
        add_request(spq_pkg::OP_ENQ, 32'd3,         32'd5);
        add_request(spq_pkg::OP_ENQ, 32'd4,         32'h8000_0000);
        add_request(spq_pkg::OP_ENQ, 32'd5,         32'h7fff_ffff);
        add_request(spq_pkg::OP_ENQ, 32'd6,         32'd1);
        add_request(spq_pkg::OP_ENQ, 32'd7,         32'hffff_fffe);
        add_request(spq_pkg::OP_ENQ, 32'd8,         32'd0);
        add_request(spq_pkg::OP_ENQ, 32'h5555_5555, 32'h8000_0001);
        add_request(spq_pkg::OP_ENQ, 32'haaaa_aaaa, 32'h7fff_fffe);
        add_request(spq_pkg::OP_ENQ, 32'd9,         32'd5);
        add_request(spq_pkg::OP_ENQ, 32'd10,        32'hffff_ffff);
        // Enqueue into a full queue. It is rejected and the store stays as it is.
        add_request(spq_pkg::OP_ENQ, 32'd11,        32'h8000_0000);
        // Dequeue a few. Both minimum-priority entries leave in arrival order.
        repeat (5)
            add_request(spq_pkg::OP_DEQ, $urandom, $urandom);

        // Random part: bursts that lean toward enqueue, toward dequeue, or are
        // balanced, so the queue swings between full and empty many times.
        total      = pending_reqs.size();
        burst_left = 0;
        enq_pct    = 50;
        while (total < ITEM_TARGET)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(60, 10);
                case ($urandom_range(2))
                    0:       enq_pct = 15;
                    1:       enq_pct = 50;
                    default: enq_pct = 85;
                endcase
            end
            if ($urandom_range(99) < enq_pct)
                add_request(spq_pkg::OP_ENQ, $urandom, pick_priority());
            else
                add_request(spq_pkg::OP_DEQ, $urandom, $urandom);
            burst_left--;
            total++;
        end

        // Hold reset, then release it on a falling edge.
        repeat (12)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // The driver pops at the falling edge, so the pending count is stable at
        // the rising edge. The monitor updates predictions at the rising edge, so
        // those are stable at the falling edge.
        while (pending_reqs.size() != 0)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_TAIL)
            @(posedge clk);

        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
